// File: rtl/rds_pkg.sv
// Shared types and constants for the ACPI resource descriptor scanner.
// Used by the descriptor walker, the record capture and the top level.
// No dependencies.
package rds_pkg;

   // Number of descriptor header bytes that are kept.
   localparam int HDR_BYTES = 18;
   // Position and span width: a descriptor spans up to 65535 + 3 bytes.
   localparam int POS_W = 17;

   // Header byte offsets inside one descriptor.
   localparam int HDR_OPCODE   = 0;
   localparam int HDR_LEN_LO   = 1;
   localparam int HDR_LEN_HI   = 2;
   localparam int HDR_GPIO_TYP = 4;
   localparam int HDR_TYPE_FLG = 5;
   localparam int HDR_I2C_FLG  = 6;
   localparam int HDR_GPIO_FLG = 7;
   localparam int HDR_PIN_CFG  = 9;
   localparam int HDR_SPEED    = 12;
   localparam int HDR_PIN_OFS  = 14;
   localparam int HDR_ADDR     = 16;
   localparam int HDR_LAST     = 17;

   // Opcodes and descriptor type codes.
   localparam logic [7:0] OP_SERIAL_BUS = 8'h8E;
   localparam logic [7:0] OP_GPIO       = 8'h8C;
   localparam logic [7:0] BUS_I2C       = 8'h01;
   localparam logic [7:0] GPIO_INT      = 8'h00;
   localparam logic [7:0] GPIO_IO       = 8'h01;
   localparam logic [15:0] PIN_NONE     = 16'hFFFF;
   // Opcode plus the two length bytes are not counted in the length field.
   localparam logic [POS_W-1:0] HDR_LEN_ADJ = POS_W'(3);

   // Interrupt trigger codes.
   localparam logic [2:0] TRIG_EDGE_RISING  = 3'd0;
   localparam logic [2:0] TRIG_EDGE_FALLING = 3'd1;
   localparam logic [2:0] TRIG_EDGE_BOTH    = 3'd2;
   localparam logic [2:0] TRIG_LEVEL_HIGH   = 3'd3;
   localparam logic [2:0] TRIG_LEVEL_LOW    = 3'd4;

   // Header bytes as seen by the decode logic.
   typedef logic [HDR_BYTES-1:0][7:0] hdr_type;

   // One byte moving from the input register into the scanner state.
   typedef struct packed {
      logic       fire;
      logic [7:0] data;
      logic       last;
   } step_type;

   typedef struct packed {
      logic        found;
      logic [2:0]  flags;
      logic [31:0] speed;
      logic [15:0] addr;
   } i2c_rec_type;

   typedef struct packed {
      logic        found;
      logic [13:0] flags;
      logic [2:0]  trig;
      logic [15:0] pin;
   } int_rec_type;

   typedef struct packed {
      logic        found;
      logic [11:0] flags;
      logic [15:0] pin;
   } io_rec_type;

   typedef struct packed {
      i2c_rec_type i2c;
      int_rec_type intr;
      io_rec_type  io;
   } result_type;

endpackage

// File: rtl/acpi_resource_descriptor_scanner.sv
// Results: the last byte passes the input register, then the result register.
// Throughput: one template byte per cycle; the input register passes a byte
// every cycle unless it holds a last byte while a finished result still waits.
// Reset: synchronous, active high; clears position, span, records and all
// valid flags. After each result the scan state returns to its reset values.
module acpi_resource_descriptor_scanner
   import rds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // Template byte stream.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // [7:0] data_byte
   input  logic         req_tlast,  // last_byte
   // Findings, one transfer per template.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] i2c_found, [3:1] i2c_flag_bits, [35:4] i2c_bus_speed,
   // [51:36] i2c_target_address, [52] int_found, [66:53] int_flag_bits,
   // [69:67] int_trigger_type, [85:70] int_pin, [86] io_found,
   // [98:87] io_flag_bits, [114:99] io_pin, [119:115] zero
   output logic [119:0] rsp_tdata
);

   logic       in_valid_ff;
   logic [7:0] in_data_ff;
   logic       in_last_ff;
   logic       advance;
   step_type   step;

   logic             rsp_valid_ff;
   result_type       rsp_data_ff;
   result_type       result;
   logic [POS_W-1:0] walk_pos;
   hdr_type          hdr_view;

   // A byte leaves the input register unless it would overwrite a waiting result.
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign step       = '{fire: advance, data: in_data_ff, last: in_last_ff};

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   rds_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .walk_pos (walk_pos),
      .hdr_view (hdr_view)
   );

   rds_capture u_capture (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .walk_pos (walk_pos),
      .hdr_view (hdr_view),
      .result   (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0,
                        rsp_data_ff.io.pin, rsp_data_ff.io.flags, rsp_data_ff.io.found,
                        rsp_data_ff.intr.pin, rsp_data_ff.intr.trig,
                        rsp_data_ff.intr.flags, rsp_data_ff.intr.found,
                        rsp_data_ff.i2c.addr, rsp_data_ff.i2c.speed,
                        rsp_data_ff.i2c.flags, rsp_data_ff.i2c.found};

`ifndef SYNTH
   // After the last byte of a template the walk starts over.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> walk_pos == '0)
      else $error("walker did not restart after the last byte");

   // A last byte never passes a result that has not been taken.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_tready |-> !advance && !req_tready)
      else $error("result overwritten before transfer");

   // A record that was not found reports zeros.
   a_int_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.intr.found |->
         rsp_data_ff.intr.pin == '0 && rsp_data_ff.intr.trig == '0)
      else $error("interrupt fields set without a decoded descriptor");

   // Trigger codes stay within the defined set.
   a_trig_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.intr.trig <= TRIG_LEVEL_LOW)
      else $error("trigger type out of range");
`endif

endmodule

// File: rtl/rds_walker.sv
// Descriptor walker: tracks the position inside the current descriptor,
// its span and the kept header bytes. Depends on rds_pkg.
module rds_walker
   import rds_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  step_type         step,
   output logic [POS_W-1:0] walk_pos,
   output hdr_type          hdr_view
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] len_ff, len_in;
   logic [POS_W-1:0] pos_inc;
   hdr_type          hdr_ff;

   // Header bytes with the byte of this transfer written through.
   always_comb begin
      for (int i = 0; i < HDR_BYTES; i++) begin
         hdr_view[i] = (pos_ff == POS_W'(i)) ? step.data : hdr_ff[i];
      end
   end

   // The span is known once the high length byte arrives.
   always_comb begin
      len_in = len_ff;
      if (pos_ff == POS_W'(HDR_LEN_HI)) begin
         len_in = POS_W'({step.data, hdr_ff[HDR_LEN_LO]}) + HDR_LEN_ADJ;
      end
   end

   // Step to the next byte, or back to the start at the end of a descriptor.
   always_comb begin
      pos_inc = pos_ff + POS_W'(1);
      if (step.last) begin
         pos_in = '0;
      end else if (pos_ff >= POS_W'(HDR_LEN_HI) && pos_inc >= len_in) begin
         pos_in = '0;
      end else begin
         pos_in = pos_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         len_ff <= '0;
      end else if (step.fire) begin
         pos_ff <= pos_in;
         len_ff <= step.last ? '0 : len_in;
      end
   end

   // Header store; entries are only read after they are written.
   always_ff @(posedge clock) begin
      for (int i = 0; i < HDR_BYTES; i++) begin
         if (step.fire && pos_ff == POS_W'(i)) begin
            hdr_ff[i] <= step.data;
         end
      end
   end

   assign walk_pos = pos_ff;

endmodule

// File: rtl/rds_capture.sv
// Record capture: decodes I2C serial-bus and GPIO descriptors from the
// header view and holds the found records. Depends on rds_pkg.
module rds_capture
   import rds_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  step_type         step,
   input  logic [POS_W-1:0] walk_pos,
   input  hdr_type          hdr_view,
   output result_type       result
);

   i2c_rec_type i2c_ff, i2c_in;
   int_rec_type int_ff, int_in;
   io_rec_type  io_ff, io_in;
   logic [7:0]  pin_low_ff;

   logic [15:0]      pin_ofs;
   logic [POS_W-1:0] pin_ofs_ext;
   logic [POS_W-1:0] commit_pos;
   logic             gpio_act;
   logic             pin_low_hit;
   logic             commit_hit;
   logic [7:0]       pin_lo;
   logic [7:0]       pin_hi;
   logic [15:0]      pin;
   logic [7:0]       gflags;
   logic             level;
   logic [1:0]       pol;
   logic [2:0]       trig;
   logic             i2c_hit;

   // Pin table offset and the position at which the pin is complete.
   always_comb begin
      pin_ofs     = {hdr_view[HDR_PIN_OFS+1], hdr_view[HDR_PIN_OFS]};
      pin_ofs_ext = POS_W'(pin_ofs);
      commit_pos  = (pin_ofs >= 16'd15) ? pin_ofs_ext + POS_W'(1) : POS_W'(15);
      gpio_act    = walk_pos >= POS_W'(15) && !int_ff.found &&
                    hdr_view[HDR_OPCODE] == OP_GPIO;
      pin_low_hit = gpio_act && walk_pos == pin_ofs_ext && pin_ofs >= 16'd16;
      commit_hit  = gpio_act && walk_pos == commit_pos;
   end

   // Pin bytes come from the header when the table sits inside it.
   always_comb begin
      pin_lo = (pin_ofs < 16'd16) ? hdr_view[{1'b0, pin_ofs[3:0]}] : pin_low_ff;
      pin_hi = (pin_ofs < 16'd15) ? hdr_view[{1'b0, pin_ofs[3:0] + 4'd1}] : step.data;
      pin    = {pin_hi, pin_lo};
   end

   // Trigger decode from the level bit and polarity.
   always_comb begin
      gflags = hdr_view[HDR_GPIO_FLG];
      level  = ~gflags[0];
      pol    = gflags[2:1];
      if (level) begin
         trig = (pol == 2'd0) ? TRIG_LEVEL_HIGH : TRIG_LEVEL_LOW;
      end else begin
         case (pol)
            2'd1:    trig = TRIG_EDGE_RISING;
            2'd2:    trig = TRIG_EDGE_BOTH;
            default: trig = TRIG_EDGE_FALLING;
         endcase
      end
   end

   // First I2C serial-bus descriptor wins.
   always_comb begin
      i2c_hit = walk_pos == POS_W'(HDR_LAST) && !i2c_ff.found &&
                hdr_view[HDR_OPCODE] == OP_SERIAL_BUS &&
                hdr_view[HDR_TYPE_FLG] == BUS_I2C;
      i2c_in = i2c_ff;
      if (i2c_hit) begin
         i2c_in.found = 1'b1;
         i2c_in.flags = {hdr_view[HDR_GPIO_FLG][0], hdr_view[HDR_I2C_FLG][1:0]};
         i2c_in.speed = {hdr_view[HDR_SPEED+3], hdr_view[HDR_SPEED+2],
                         hdr_view[HDR_SPEED+1], hdr_view[HDR_SPEED]};
         i2c_in.addr  = {hdr_view[HDR_ADDR+1], hdr_view[HDR_ADDR]};
      end
   end

   // GPIO records: first interrupt, and io descriptors until then.
   always_comb begin
      int_in = int_ff;
      io_in  = io_ff;
      if (commit_hit && pin != PIN_NONE) begin
         if (hdr_view[HDR_GPIO_TYP] == GPIO_INT) begin
            int_in.found = 1'b1;
            int_in.flags = {hdr_view[HDR_PIN_CFG], gflags[4], gflags[3], pol, level,
                            hdr_view[HDR_TYPE_FLG][0]};
            int_in.trig  = trig;
            int_in.pin   = pin;
         end else if (hdr_view[HDR_GPIO_TYP] == GPIO_IO) begin
            io_in.found = 1'b1;
            io_in.flags = {hdr_view[HDR_PIN_CFG], gflags[3], gflags[1:0],
                           hdr_view[HDR_TYPE_FLG][0]};
            io_in.pin   = pin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i2c_ff <= '0;
         int_ff <= '0;
         io_ff  <= '0;
      end else if (step.fire) begin
         if (step.last) begin
            i2c_ff <= '0;
            int_ff <= '0;
            io_ff  <= '0;
         end else begin
            i2c_ff <= i2c_in;
            int_ff <= int_in;
            io_ff  <= io_in;
         end
      end
   end

   // Low pin byte when the pin table starts at offset 16 or beyond.
   always_ff @(posedge clock) begin
      if (step.fire && pin_low_hit) begin
         pin_low_ff <= step.data;
      end
   end

   assign result = '{i2c: i2c_in, intr: int_in, io: io_in};

endmodule

// File: tb/acpi_resource_descriptor_scanner_tb.sv
`timescale 1ns / 100ps
// Testbench for acpi_resource_descriptor_scanner: streams resource templates byte by byte,
// predicts the findings of each template and checks every result transfer field by field.
// Depends on rds_pkg and the scanner top level only.
module acpi_resource_descriptor_scanner_tb;
   import rds_pkg::*;

   localparam int RESET_CYCLES = 3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_OFF_CYCLES = 500;
   localparam int BYTES_PER_PHASE = 50;
   localparam int TEMPLATES_PER_PHASE = 1;
   localparam int MAX_PRINTS = 40;
   // High byte of the pin-table offset, and the first position past that field.
   localparam int PIN_OFS_HI = HDR_PIN_OFS + 1;
   localparam int PIN_BODY_START = HDR_PIN_OFS + 2;
   // GPIO polarity codes (bits 2:1 of the interrupt flags byte).
   localparam logic [1:0] POL_HIGH = 2'd0;
   localparam logic [1:0] POL_LOW = 2'd1;
   localparam logic [1:0] POL_BOTH = 2'd2;

   typedef logic [7:0] octet_q[$];

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;  // [7:0] data_byte
   logic req_tlast = 1'b0;      // last_byte
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;     // packed findings, i2c_found in bit 0 up to io_pin

   int send_idle = 0;
   int recv_stall = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int sent_bytes = 0;
   int sent_templates = 0;

   acpi_resource_descriptor_scanner u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Walks the template like the scanner does and queues the findings of each template.
   class scan_scoreboard;
      int unsigned pos;
      int unsigned span;
      logic [7:0] hdr[HDR_BYTES];
      logic [7:0] pin_lo;
      i2c_rec_type i2c_rec;
      int_rec_type int_rec;
      io_rec_type io_rec;
      result_type expected_findings[$];
      int errors;
      int results_seen;

      function new();
         errors = 0;
         results_seen = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         pos = 0;
         span = 0;
         foreach (hdr[i]) hdr[i] = '0;
         pin_lo = '0;
         i2c_rec = '0;
         int_rec = '0;
         io_rec = '0;
      endfunction

      // Decodes one GPIO descriptor once its pin number is complete.
      function void decode_gpio(logic [15:0] pin);
         logic [7:0] gf;
         logic [7:0] cfg;
         logic cons;
         logic level;
         logic [1:0] pol;
         gf = hdr[HDR_GPIO_FLG];
         cfg = hdr[HDR_PIN_CFG];
         cons = hdr[HDR_TYPE_FLG][0];
         level = ~gf[0];
         pol = gf[2:1];
         if (pin == PIN_NONE) return;
         if (hdr[HDR_GPIO_TYP] == GPIO_INT) begin
            int_rec.found = 1'b1;
            int_rec.flags = {cfg, gf[4], gf[3], pol, level, cons};
            if (level) begin
               int_rec.trig = (pol == POL_HIGH) ? TRIG_LEVEL_HIGH : TRIG_LEVEL_LOW;
            end else if (pol == POL_LOW) begin
               int_rec.trig = TRIG_EDGE_RISING;
            end else if (pol == POL_BOTH) begin
               int_rec.trig = TRIG_EDGE_BOTH;
            end else begin
               int_rec.trig = TRIG_EDGE_FALLING;
            end
            int_rec.pin = pin;
         end else if (hdr[HDR_GPIO_TYP] == GPIO_IO) begin
            io_rec.found = 1'b1;
            io_rec.flags = {cfg, gf[3], gf[1:0], cons};
            io_rec.pin = pin;
         end
      endfunction

      // Notes one accepted template byte.
      function void take_byte(logic [7:0] b, logic last);
         int unsigned p;
         int unsigned commit_pos;
         logic [7:0] lo;
         logic [7:0] hi;
         result_type r;
         if (pos < HDR_BYTES) hdr[pos] = b;
         if (pos == HDR_LEN_HI) span = 32'({b, hdr[HDR_LEN_LO]}) + HDR_LEN_ADJ;

         // The first I2C serial bus descriptor completes at its last header byte.
         if (pos == HDR_LAST && !i2c_rec.found && hdr[HDR_OPCODE] == OP_SERIAL_BUS &&
             hdr[HDR_TYPE_FLG] == BUS_I2C) begin
            i2c_rec.found = 1'b1;
            i2c_rec.flags = {hdr[HDR_GPIO_FLG][0], hdr[HDR_I2C_FLG][1:0]};
            i2c_rec.speed = {hdr[HDR_SPEED + 3], hdr[HDR_SPEED + 2],
                             hdr[HDR_SPEED + 1], hdr[HDR_SPEED]};
            i2c_rec.addr = {hdr[HDR_ADDR + 1], hdr[HDR_ADDR]};
         end

         // GPIO descriptors, followed through the pin-table offset.
         if (pos >= PIN_OFS_HI && !int_rec.found && hdr[HDR_OPCODE] == OP_GPIO) begin
            p = 32'({hdr[PIN_OFS_HI], hdr[HDR_PIN_OFS]});
            commit_pos = (p + 1 > PIN_OFS_HI) ? p + 1 : PIN_OFS_HI;
            if (pos == p && p >= PIN_BODY_START) pin_lo = b;
            if (pos == commit_pos) begin
               lo = (p < PIN_BODY_START) ? hdr[p] : pin_lo;
               hi = (p + 1 < PIN_BODY_START) ? hdr[p + 1] : b;
               decode_gpio({hi, lo});
            end
         end

         if (pos >= HDR_LEN_HI && pos + 1 >= span) pos = 0;
         else pos = pos + 1;

         if (last) begin
            r.i2c = i2c_rec;
            r.intr = int_rec;
            r.io = io_rec;
            expected_findings.push_back(r);
            clear_scan();
         end
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= MAX_PRINTS)
            $display("mismatch in result %0d: %s got %0h expected %0h", results_seen, what,
                     got, want);
      endtask

      task check_field(string what, logic [31:0] got, logic [31:0] want);
         if (got !== want) report_mismatch(what, got, want);
      endtask

      // Compares one result transfer with the oldest expected findings.
      task check_findings(logic [119:0] got);
         result_type want;
         results_seen++;
         if (expected_findings.size() == 0) begin
            report_mismatch("result with no template pending", 1, 0);
            return;
         end
         want = expected_findings.pop_front();
         check_field("i2c_found", 32'(got[0]), 32'(want.i2c.found));
         check_field("i2c_flag_bits", 32'(got[3:1]), 32'(want.i2c.flags));
         check_field("i2c_bus_speed", got[35:4], want.i2c.speed);
         check_field("i2c_target_address", 32'(got[51:36]), 32'(want.i2c.addr));
         check_field("int_found", 32'(got[52]), 32'(want.intr.found));
         check_field("int_flag_bits", 32'(got[66:53]), 32'(want.intr.flags));
         check_field("int_trigger_type", 32'(got[69:67]), 32'(want.intr.trig));
         check_field("int_pin", 32'(got[85:70]), 32'(want.intr.pin));
         check_field("io_found", 32'(got[86]), 32'(want.io.found));
         check_field("io_flag_bits", 32'(got[98:87]), 32'(want.io.flags));
         check_field("io_pin", 32'(got[114:99]), 32'(want.io.pin));
         check_field("padding", 32'(got[119:115]), 32'd0);
      endtask
   endclass

   scan_scoreboard board;

   // Clock with a 20 ns period.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Cycle counter that ends a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("acpi_resource_descriptor_scanner_tb: done, errors");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   // Outputs are sampled at the falling edge; the transfer completes at the next rising edge.
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_findings(rsp_tdata);
   end

   // Offers one byte, idling at random first, and returns at the edge of its transfer.
   task automatic send_byte(logic [7:0] data, logic last);
      logic taken;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tlast <= last;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end
      board.take_byte(data, last);
      sent_bytes++;
   endtask

   task automatic send_template(octet_q t);
      for (int i = 0; i < t.size(); i++) send_byte(t[i], i == t.size() - 1);
      sent_templates++;
   endtask

   task automatic set_phase(int idle, int stall);
      req_tvalid <= 1'b0;
      @(negedge clock);
      send_idle = idle;
      recv_stall = stall;
      @(posedge clock);
   endtask

   // Descriptor with random body; cap cuts it short for templates that end inside it.
   function automatic octet_q make_desc(logic [7:0] op, int unsigned len, int unsigned cap);
      octet_q d;
      int unsigned size;
      size = len + 3;
      if (size > cap) size = cap;
      for (int i = 0; i < size; i++) d.push_back(8'($urandom));
      d[HDR_OPCODE] = op;
      if (size > HDR_LEN_LO) d[HDR_LEN_LO] = len[7:0];
      if (size > HDR_LEN_HI) d[HDR_LEN_HI] = len[15:8];
      return d;
   endfunction

   function automatic octet_q make_i2c(int unsigned len, int unsigned cap);
      octet_q d;
      d = make_desc(OP_SERIAL_BUS, len, cap);
      if (d.size() > HDR_TYPE_FLG) d[HDR_TYPE_FLG] = BUS_I2C;
      return d;
   endfunction

   function automatic octet_q make_gpio(logic [7:0] kind, logic [7:0] gflags, int unsigned ofs,
                                        logic [15:0] pin, int unsigned len, int unsigned cap);
      octet_q d;
      d = make_desc(OP_GPIO, len, cap);
      if (d.size() > HDR_GPIO_TYP) d[HDR_GPIO_TYP] = kind;
      if (d.size() > HDR_GPIO_FLG) d[HDR_GPIO_FLG] = gflags;
      if (d.size() > HDR_PIN_OFS) d[HDR_PIN_OFS] = ofs[7:0];
      if (d.size() > PIN_OFS_HI) d[PIN_OFS_HI] = ofs[15:8];
      if (ofs >= PIN_BODY_START && ofs < d.size()) d[ofs] = pin[7:0];
      if (ofs >= PIN_BODY_START && ofs + 1 < d.size()) d[ofs + 1] = pin[15:8];
      return d;
   endfunction

   // Random template: a short chain of I2C, GPIO and other descriptors, sometimes cut short.
   function automatic octet_q random_template();
      octet_q t;
      octet_q d;
      int unsigned n;
      int unsigned pick;
      int unsigned len;
      int unsigned ofs;
      logic [7:0] kind;
      logic [15:0] pin;
      bit cut;
      n = $urandom_range(4, 1);
      cut = 1'b0;
      for (int k = 0; k < n && !cut; k++) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(14, 0) : $urandom_range(24, 15);
            d = make_i2c(len, len + 3);
            if ($urandom_range(4) == 0 && d.size() > HDR_TYPE_FLG)
               d[HDR_TYPE_FLG] = 8'($urandom);
         end else if (pick < 72) begin
            ofs = ($urandom_range(9) == 0) ? $urandom_range(15, 0) : $urandom_range(28, 16);
            len = ((ofs >= PIN_BODY_START) ? ofs - 1 : 13) + $urandom_range(5, 0);
            if ($urandom_range(9) == 0) len = len - 1;
            pick = $urandom_range(99);
            kind = (pick < 45) ? GPIO_INT : (pick < 90) ? GPIO_IO : 8'($urandom);
            pick = $urandom_range(99);
            pin = (pick < 10) ? PIN_NONE : (pick < 15) ? 16'h0000 : 16'($urandom);
            d = make_gpio(kind, 8'($urandom), ofs, pin, len, len + 3);
         end else if (pick < 92) begin
            d = make_desc(8'($urandom), $urandom_range(20, 0), len + 64);
         end else begin
            // Long descriptor: the template ends inside it.
            len = $urandom_range(65535, 64);
            pick = $urandom_range(2);
            if (pick == 0) d = make_i2c(len, $urandom_range(40, 1));
            else if (pick == 1)
               d = make_gpio(GPIO_INT, 8'($urandom), $urandom_range(65535, 16),
                             16'($urandom), len, $urandom_range(40, 1));
            else d = make_desc(8'($urandom), len, $urandom_range(40, 1));
            cut = 1'b1;
         end
         t = {t, d};
      end
      if (!cut && $urandom_range(6) == 0) t = t[0 : $urandom_range(t.size(), 1) - 1];
      return t;
   endfunction

   // Directed templates: field extremes, every trigger decode and the corner cases.
   task automatic run_directed();
      octet_q d;
      octet_q t;
      // A template of one byte, and one of zero-length descriptors only.
      t = {8'hFF};
      send_template(t);
      t = {8'h00, 8'h00, 8'h00, 8'h00};
      send_template(t);
      // I2C with all fields at their maximum; a second I2C must not replace it.
      d = make_i2c(15, 18);
      for (int i = HDR_I2C_FLG; i < HDR_BYTES; i++) d[i] = 8'hFF;
      t = {d, make_i2c(20, 23)};
      send_template(t);
      // I2C with all fields zero, ending on the byte that completes it.
      d = make_i2c(16'hFFFF, HDR_BYTES);
      for (int i = HDR_I2C_FLG; i < HDR_BYTES; i++) d[i] = 8'h00;
      send_template(d);
      // Template ending one byte before the I2C record is complete.
      send_template(make_i2c(20, HDR_LAST));
      // Too short to hold an I2C record, then a zero-length descriptor, then a good one.
      t = {make_i2c(14, 17), make_desc(8'h8E, 0, 3), make_i2c(15, 18)};
      send_template(t);
      // Every combination of edge/level and polarity for the interrupt trigger.
      for (int g = 0; g < 8; g++) begin
         d = make_gpio(GPIO_INT, 8'(g) | (8'($urandom) & 8'hF8), PIN_BODY_START,
                       16'($urandom_range(16'hFFFE, 0)), 15, 18);
         send_template(d);
      end
      // Two io descriptors with extreme flags and pins, then an interrupt, then an io
      // descriptor that comes too late to count.
      d = make_gpio(GPIO_IO, 8'hFF, 20, 16'hFFFE, 19, 22);
      d[HDR_TYPE_FLG] = 8'hFF;
      d[HDR_PIN_CFG] = 8'hFF;
      t = {make_gpio(GPIO_IO, 8'h00, 16, 16'h0000, 15, 18), d,
           make_gpio(GPIO_INT, 8'hFF, 17, 16'h0000, 18, 21),
           make_gpio(GPIO_IO, 8'h00, 16, 16'h1234, 15, 18)};
      send_template(t);
      // Invalid pin and an unknown GPIO type update nothing; the interrupt after them is taken.
      t = {make_gpio(GPIO_INT, 8'h01, 16, PIN_NONE, 15, 18),
           make_gpio(8'h02, 8'h00, 16, 16'h4321, 15, 18),
           make_gpio(GPIO_INT, 8'h00, 16, 16'h8001, 16, 19)};
      send_template(t);
      // Pin-table offset inside the header, at its edge, and pin high byte past the span.
      send_template(make_gpio(GPIO_IO, 8'($urandom), 10, 16'h0, 13, 16));
      send_template(make_gpio(GPIO_INT, 8'($urandom), 14, 16'h0, 13, 16));
      send_template(make_gpio(GPIO_IO, 8'($urandom), 15, 16'h0, 14, 17));
      t = {make_gpio(GPIO_INT, 8'h00, 15, 16'h0, 13, 16),
           make_gpio(GPIO_INT, 8'h00, 20, 16'h0055, 18, 21)};
      send_template(t);
      // Largest pin-table offset in a descriptor of maximum length, cut short.
      send_template(make_gpio(GPIO_INT, 8'h00, 16'hFFFF, 16'h0, 16'hFFFF, 40));
   endtask

   initial begin
      int idle_of[4];
      int stall_of[4];
      int base_bytes;
      int base_templates;
      board = new();
      idle_of = '{0, 81, 0, 37};
      stall_of = '{0, 0, 81, 37};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      set_phase(0, 0);
      run_directed();

      // Random templates in the four idling phases; long hold-offs in the first and last.
      for (int ph = 0; ph < 4; ph++) begin
         set_phase(idle_of[ph], stall_of[ph]);
         base_bytes = sent_bytes;
         base_templates = sent_templates;
         if (ph == 0 || ph == 3) hold_req <= hold_req + 1;
         while (sent_bytes - base_bytes < BYTES_PER_PHASE ||
                sent_templates - base_templates < TEMPLATES_PER_PHASE)
            send_template(random_template());
      end

      req_tvalid <= 1'b0;
      while (board.expected_findings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("acpi_resource_descriptor_scanner_tb: done, clean");
      end else begin
         $display("acpi_resource_descriptor_scanner_tb: done, errors");
      end
      $finish;
   end

endmodule
